// ----- hw/rtl/dksp_pkg.sv -----
// Package for the domain key stream parser: phase codes, character constants,
// match tables and the per-byte result type. No dependencies.
`default_nettype none

package dksp_pkg;

  typedef enum logic [2:0] {
    PH_PREFIX = 3'd0,
    PH_KIND   = 3'd1,
    PH_KEY    = 3'd2,
    PH_NS     = 3'd3,
    PH_NAME   = 3'd4
  } dksp_phase_e;

  localparam int unsigned PrefixLen = 7;
  localparam int unsigned AttLen    = 10;
  localparam int unsigned PdfLen    = 3;

  localparam logic [3:0] PREFIX_LEN = 4'(PrefixLen);
  localparam logic [3:0] ATT_LEN    = 4'(AttLen);
  localparam logic [3:0] PDF_LEN    = 4'(PdfLen);

  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_PERCENT = 8'h25;

  // kind_candidates bits
  localparam logic [1:0] CAND_BOTH = 2'b11;
  localparam logic [1:0] CAND_ATT  = 2'b01;
  localparam logic [1:0] CAND_PDF  = 2'b10;

  localparam logic [1:0] SEG_KEY  = 2'd0;
  localparam logic [1:0] SEG_NS   = 2'd1;
  localparam logic [1:0] SEG_NAME = 2'd2;

  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_HIGH = 2'd1;
  localparam logic [1:0] ESC_LOW  = 2'd2;

  // One result item.
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] decoded_byte;
    logic [1:0] segment;
    logic       key_done;
    logic       key_ok;
    logic       kind_pdf;
  } dksp_result_t;

  // "dom:v1/"
  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h64;
      3'd1:    ch = 8'h6F;
      3'd2:    ch = 8'h6D;
      3'd3:    ch = 8'h3A;
      3'd4:    ch = 8'h76;
      3'd5:    ch = 8'h31;
      3'd6:    ch = 8'h2F;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // "attachment"
  function automatic logic [7:0] att_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h61;
      4'd1:    ch = 8'h74;
      4'd2:    ch = 8'h74;
      4'd3:    ch = 8'h61;
      4'd4:    ch = 8'h63;
      4'd5:    ch = 8'h68;
      4'd6:    ch = 8'h6D;
      4'd7:    ch = 8'h65;
      4'd8:    ch = 8'h6E;
      4'd9:    ch = 8'h74;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // "pdf"
  function automatic logic [7:0] pdf_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = 8'h70;
      2'd1:    ch = 8'h64;
      2'd2:    ch = 8'h66;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Returns {is_hex, nibble}.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // [0-9a-z_.]
  function automatic logic token_char(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
           (c == 8'h5F) || (c == 8'h2E);
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/dksp_input_reg.sv -----
// Input register stage of the domain key stream parser.
// Depends on nothing but the handshake from the stage behind it.
`default_nettype none

module dksp_input_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] key_byte_i,
  input  logic       last_byte_i,
  input  logic       advance_i,   // downstream takes the held request this cycle
  output logic       valid_o,
  output logic [7:0] key_byte_o,
  output logic       last_byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       last_q;

  // Full and not draining: hold off the upstream side.
  assign in_stall_o = valid_q && !advance_i;
  assign valid_d    = in_stall_o ? valid_q : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      byte_q <= key_byte_i;
      last_q <= last_byte_i;
    end
  end

  assign valid_o     = valid_q;
  assign key_byte_o  = byte_q;
  assign last_byte_o = last_q;

endmodule

`default_nettype wire

// ----- hw/rtl/dksp_parser.sv -----
// Parse state and per-byte decision logic of the domain key stream parser.
// Uses dksp_pkg for phase codes, match tables and the result type.
`default_nettype none

module dksp_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,      // commit this byte's state update
  input  logic [7:0]            key_byte_i,
  input  logic                  last_byte_i,
  output dksp_pkg::dksp_result_t result_o
);
  import dksp_pkg::*;

  dksp_phase_e phase_q, phase_d;
  logic [3:0]  match_pos_q, match_pos_d;
  logic [1:0]  cand_q, cand_d;
  logic [1:0]  esc_q, esc_d;
  logic [3:0]  high_q, high_d;
  logic        nonempty_q, nonempty_d;
  logic        failed_q, failed_d;

  logic [7:0]  c;
  logic [4:0]  hex;
  logic        emit;
  logic [7:0]  val;
  logic [1:0]  seg;
  logic        ok;

  assign c   = key_byte_i;
  assign hex = hex_decode(c);

  always_comb begin
    phase_d     = phase_q;
    match_pos_d = match_pos_q;
    cand_d      = cand_q;
    esc_d       = esc_q;
    high_d      = high_q;
    nonempty_d  = nonempty_q;
    failed_d    = failed_q;
    emit        = 1'b0;
    val         = 8'h00;
    seg         = SEG_KEY;
    ok          = 1'b0;

    if (!failed_q) begin
      case (phase_q)
        PH_PREFIX: begin
          if (match_pos_q < PREFIX_LEN && c == prefix_char(match_pos_q[2:0])) begin
            if (match_pos_q + 4'd1 == PREFIX_LEN) begin
              phase_d     = PH_KIND;
              match_pos_d = 4'd0;
              cand_d      = CAND_BOTH;
            end else begin
              match_pos_d = match_pos_q + 4'd1;
            end
          end else begin
            failed_d = 1'b1;
          end
        end
        PH_KIND: begin
          if (c == CH_SLASH) begin
            if (cand_q[0] && match_pos_q == ATT_LEN) begin
              cand_d = CAND_ATT;
            end else if (cand_q[1] && match_pos_q == PDF_LEN) begin
              cand_d = CAND_PDF;
            end else begin
              failed_d = 1'b1;
            end
            if (!failed_d) begin
              phase_d     = PH_KEY;
              match_pos_d = 4'd0;
              nonempty_d  = 1'b0;
              esc_d       = ESC_NONE;
            end
          end else begin
            if (!(match_pos_q < ATT_LEN && c == att_char(match_pos_q))) begin
              cand_d[0] = 1'b0;
            end
            if (!(match_pos_q < PDF_LEN && c == pdf_char(match_pos_q[1:0]))) begin
              cand_d[1] = 1'b0;
            end
            if (cand_d == 2'b00) begin
              failed_d = 1'b1;
            end
            if (match_pos_q < ATT_LEN) begin
              match_pos_d = match_pos_q + 4'd1;
            end
          end
        end
        PH_KEY: begin
          seg = SEG_KEY;
          if (esc_q != ESC_NONE) begin
            if (!hex[4]) begin
              failed_d = 1'b1;
            end else if (esc_q == ESC_HIGH) begin
              high_d = hex[3:0];
              esc_d  = ESC_LOW;
            end else begin
              emit  = 1'b1;
              val   = {high_q, hex[3:0]};
              esc_d = ESC_NONE;
            end
          end else if (c == CH_SLASH) begin
            if (!nonempty_q) begin
              failed_d = 1'b1;
            end else begin
              phase_d    = PH_NS;
              nonempty_d = 1'b0;
            end
          end else if (c == CH_PERCENT) begin
            esc_d      = ESC_HIGH;
            nonempty_d = 1'b1;
          end else begin
            emit       = 1'b1;
            val        = c;
            nonempty_d = 1'b1;
          end
        end
        PH_NS: begin
          if (c == CH_SLASH) begin
            if (!nonempty_q) begin
              failed_d = 1'b1;
            end else begin
              phase_d    = PH_NAME;
              nonempty_d = 1'b0;
            end
          end else if (token_char(c)) begin
            emit       = 1'b1;
            val        = c;
            seg        = SEG_NS;
            nonempty_d = 1'b1;
          end else begin
            failed_d = 1'b1;
          end
        end
        PH_NAME: begin
          if (token_char(c)) begin
            emit       = 1'b1;
            val        = c;
            seg        = SEG_NAME;
            nonempty_d = 1'b1;
          end else begin
            failed_d = 1'b1;
          end
        end
        default: begin
          failed_d = 1'b1;
        end
      endcase
    end

    if (failed_d) begin
      emit = 1'b0;
      val  = 8'h00;
    end
    if (!emit) begin
      seg = SEG_KEY;
    end

    // Verdict, then start over for the next key.
    if (last_byte_i) begin
      ok          = !failed_d && phase_d == PH_NAME && nonempty_d;
      phase_d     = PH_PREFIX;
      match_pos_d = 4'd0;
      cand_d      = CAND_BOTH;
      esc_d       = ESC_NONE;
      high_d      = 4'd0;
      nonempty_d  = 1'b0;
      failed_d    = 1'b0;
    end

    result_o.byte_valid   = emit;
    result_o.decoded_byte = val;
    result_o.segment      = seg;
    result_o.key_done     = last_byte_i;
    result_o.key_ok       = ok;
    result_o.kind_pdf     = ok && cand_q == CAND_PDF;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_PREFIX;
      match_pos_q <= 4'd0;
      cand_q      <= CAND_BOTH;
      esc_q       <= ESC_NONE;
      high_q      <= 4'd0;
      nonempty_q  <= 1'b0;
      failed_q    <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      match_pos_q <= match_pos_d;
      cand_q      <= cand_d;
      esc_q       <= esc_d;
      high_q      <= high_d;
      nonempty_q  <= nonempty_d;
      failed_q    <= failed_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dksp_output_reg.sv -----
// Result register stage of the domain key stream parser.
// Uses dksp_pkg for the result type.
`default_nettype none

module dksp_output_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  dksp_pkg::dksp_result_t result_i,
  output logic                  advance_o,  // stage can take a new request
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output dksp_pkg::dksp_result_t result_o
);
  import dksp_pkg::*;

  logic         valid_q;
  dksp_result_t result_q;

  assign advance_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && valid_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

`default_nettype wire

// ----- hw/rtl/domain_key_stream_parser_top.sv -----
// Top level of the domain key stream parser: input register, parser, result register.
// Depends on dksp_pkg, dksp_input_reg, dksp_parser and dksp_output_reg.
//
//   channel   valid        stall        payload
//   --------  -----------  -----------  ---------------------------------------------
//   input     in_valid_i   in_stall_o   key_byte_i, last_byte_i
//   result    out_valid_o  out_stall_i  byte_valid_o, decoded_byte_o, segment_o,
//                                       key_done_o, key_ok_o, kind_pdf_o
//
// One request per cycle sustained while out_stall_i stays low. A request lands in the
// input register when accepted; its parse decision, computed from that register, lands
// in the result register when that register advances and drives the result outputs.
// Reset (rst_ni low, async) empties both stages and puts the parser at the prefix.
// A stall on the result side holds the result register; an empty input register still
// takes one more request, then in_stall_o rises until the result drains.
`default_nettype none

module domain_key_stream_parser_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] key_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       byte_valid_o,
  output logic [7:0] decoded_byte_o,
  output logic [1:0] segment_o,
  output logic       key_done_o,
  output logic       key_ok_o,
  output logic       kind_pdf_o
);
  import dksp_pkg::*;

  logic         advance;
  logic         s1_valid;
  logic [7:0]   s1_byte;
  logic         s1_last;
  dksp_result_t parse_res;
  dksp_result_t out_res;

  dksp_input_reg u_input_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .key_byte_i  (key_byte_i),
    .last_byte_i (last_byte_i),
    .advance_i   (advance),
    .valid_o     (s1_valid),
    .key_byte_o  (s1_byte),
    .last_byte_o (s1_last)
  );

  // Parse state commits only when the held byte moves into the result register.
  dksp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (s1_valid && advance),
    .key_byte_i  (s1_byte),
    .last_byte_i (s1_last),
    .result_o    (parse_res)
  );

  dksp_output_reg u_output_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s1_valid),
    .result_i    (parse_res),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_res)
  );

  assign byte_valid_o   = out_res.byte_valid;
  assign decoded_byte_o = out_res.decoded_byte;
  assign segment_o      = out_res.segment;
  assign key_done_o     = out_res.key_done;
  assign key_ok_o       = out_res.key_ok;
  assign kind_pdf_o     = out_res.kind_pdf;

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for domain_key_stream_parser_top: directed and random serialized keys,
// checked per result against an in-bench parse of the same byte stream.
// Depends on dksp_pkg and the parser RTL.

module tb_top;
  import dksp_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int RANDOM_BYTES   = 1500;
  localparam int PRINT_LIMIT    = 40;

  // Literal texts, first character in the top byte.
  localparam logic [55:0] PREFIX_TXT = "dom:v1/";
  localparam logic [79:0] ATT_TXT    = "attachment";
  localparam logic [23:0] PDF_TXT    = "pdf";

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] key_byte_i;
  logic       last_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       byte_valid_o;
  logic [7:0] decoded_byte_o;
  logic [1:0] segment_o;
  logic       key_done_o;
  logic       key_ok_o;
  logic       kind_pdf_o;

  domain_key_stream_parser_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .key_byte_i     (key_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .byte_valid_o   (byte_valid_o),
    .decoded_byte_o (decoded_byte_o),
    .segment_o      (segment_o),
    .key_done_o     (key_done_o),
    .key_ok_o       (key_ok_o),
    .kind_pdf_o     (kind_pdf_o)
  );

  // Parse state mirrored in the bench.
  dksp_phase_e p_phase;
  logic [3:0]  p_pos;
  logic [1:0]  p_cand;
  logic [1:0]  p_esc;
  logic [3:0]  p_hi;
  logic        p_nonempty;
  logic        p_failed;

  dksp_result_t parse_results_q[$];  // expected results, oldest first
  logic [7:0]   key_buf[$];          // key being built for the next send
  int           mismatch_count;
  int           bytes_sent;
  int           burst_left;
  int           idle_cycles;

  string token_set = "0123456789abcdefghijklmnopqrstuvwxyz_.";
  string hex_set   = "0123456789abcdefABCDEF";

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Parse model
  // ---------------------------------------------------------------------------

  function automatic void parse_restart();
    p_phase    = PH_PREFIX;
    p_pos      = '0;
    p_cand     = CAND_BOTH;
    p_esc      = ESC_NONE;
    p_hi       = '0;
    p_nonempty = 1'b0;
    p_failed   = 1'b0;
  endfunction

  function automatic logic [7:0] att_at(input logic [3:0] i);
    return (i < ATT_LEN) ? ATT_TXT[8*(9-i) +: 8] : 8'h00;
  endfunction

  function automatic logic [7:0] pdf_at(input logic [3:0] i);
    return (i < PDF_LEN) ? PDF_TXT[8*(2-i) +: 8] : 8'h00;
  endfunction

  // {is hex digit, nibble}
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 10)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 10)};
    return 5'b0;
  endfunction

  function automatic logic is_name_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || c == "_" || c == ".";
  endfunction

  // Advances the parse by one byte and returns the result the block must give.
  function automatic dksp_result_t parse_key_byte(input logic [7:0] c, input logic lst);
    dksp_result_t r;
    logic         emit;
    logic [7:0]   val;
    logic [1:0]   seg;
    logic [4:0]   hx;
    logic         ok;
    emit = 1'b0;
    val  = '0;
    seg  = SEG_KEY;
    if (!p_failed) begin
      case (p_phase)
        PH_PREFIX: begin
          if (p_pos < PREFIX_LEN && c == PREFIX_TXT[8*(6-p_pos) +: 8]) begin
            p_pos = p_pos + 4'd1;
            if (p_pos == PREFIX_LEN) begin
              p_phase = PH_KIND;
              p_pos   = '0;
              p_cand  = CAND_BOTH;
            end
          end else begin
            p_failed = 1'b1;
          end
        end
        PH_KIND: begin
          if (c == CH_SLASH) begin
            // the slash picks whichever candidate matched in full
            if (p_cand[0] && p_pos == ATT_LEN) p_cand = CAND_ATT;
            else if (p_cand[1] && p_pos == PDF_LEN) p_cand = CAND_PDF;
            else p_failed = 1'b1;
            if (!p_failed) begin
              p_phase    = PH_KEY;
              p_pos      = '0;
              p_nonempty = 1'b0;
              p_esc      = ESC_NONE;
            end
          end else begin
            if (!(p_pos < ATT_LEN && c == att_at(p_pos))) p_cand[0] = 1'b0;
            if (!(p_pos < PDF_LEN && c == pdf_at(p_pos))) p_cand[1] = 1'b0;
            if (p_cand == 2'b00) p_failed = 1'b1;
            if (p_pos < ATT_LEN) p_pos = p_pos + 4'd1;
          end
        end
        PH_KEY: begin
          if (p_esc != ESC_NONE) begin
            hx = nibble_of(c);
            if (!hx[4]) begin
              p_failed = 1'b1;
            end else if (p_esc == ESC_HIGH) begin
              p_hi  = hx[3:0];
              p_esc = ESC_LOW;
            end else begin
              emit  = 1'b1;
              val   = {p_hi, hx[3:0]};
              p_esc = ESC_NONE;
            end
          end else if (c == CH_SLASH) begin
            if (!p_nonempty) begin
              p_failed = 1'b1;
            end else begin
              p_phase    = PH_NS;
              p_nonempty = 1'b0;
            end
          end else if (c == CH_PERCENT) begin
            p_esc      = ESC_HIGH;
            p_nonempty = 1'b1;
          end else begin
            emit       = 1'b1;
            val        = c;
            p_nonempty = 1'b1;
          end
        end
        PH_NS: begin
          if (c == CH_SLASH) begin
            if (!p_nonempty) begin
              p_failed = 1'b1;
            end else begin
              p_phase    = PH_NAME;
              p_nonempty = 1'b0;
            end
          end else if (is_name_char(c)) begin
            emit       = 1'b1;
            val        = c;
            seg        = SEG_NS;
            p_nonempty = 1'b1;
          end else begin
            p_failed = 1'b1;
          end
        end
        PH_NAME: begin
          if (is_name_char(c)) begin
            emit       = 1'b1;
            val        = c;
            seg        = SEG_NAME;
            p_nonempty = 1'b1;
          end else begin
            p_failed = 1'b1;
          end
        end
        default: p_failed = 1'b1;
      endcase
    end
    if (p_failed) begin
      emit = 1'b0;
      val  = '0;
      seg  = SEG_KEY;
    end
    r.byte_valid   = emit;
    r.decoded_byte = val;
    r.segment      = emit ? seg : SEG_KEY;
    r.key_done     = lst;
    r.key_ok       = 1'b0;
    r.kind_pdf     = 1'b0;
    if (lst) begin
      ok         = !p_failed && p_phase == PH_NAME && p_nonempty;
      r.key_ok   = ok;
      r.kind_pdf = ok && p_cand == CAND_PDF;
      parse_restart();
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Sends one byte; the sender runs in bursts with random gaps between them.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 80 : 12);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    key_byte_i  <= b;
    last_byte_i <= lst;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    parse_results_q.insert(parse_results_q.size(), parse_key_byte(b, lst));
    bytes_sent++;
  endtask

  // Sends key_buf as one key, last flag on its final byte.
  task automatic send_key();
    for (int i = 0; i < key_buf.size(); i++) begin
      send_byte(key_buf[i], i == key_buf.size() - 1);
    end
    key_buf.delete();
  endtask

  // Holds off new requests until every expected result is back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (parse_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    burst_left = 0;
  endtask

  // Appends one byte to the key under construction.
  function automatic void put_byte(input logic [7:0] b);
    key_buf.insert(key_buf.size(), b);
  endfunction

  function automatic void put_str(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  function automatic void put_tokens(input int n);
    repeat (n) put_byte(token_set[$urandom_range(0, token_set.len() - 1)]);
  endfunction

  // Raw bytes (anything but '%' and '/') mixed with escapes of random case.
  function automatic void put_carrier(input int n);
    logic [7:0] c;
    repeat (n) begin
      if ($urandom_range(0, 2) == 0) begin
        put_byte(CH_PERCENT);
        put_byte(hex_set[$urandom_range(0, hex_set.len() - 1)]);
        put_byte(hex_set[$urandom_range(0, hex_set.len() - 1)]);
      end else begin
        do c = 8'($urandom_range(0, 255)); while (c == CH_PERCENT || c == CH_SLASH);
        put_byte(c);
      end
    end
  endfunction

  // Kind segment: mostly the two real words, sometimes a near miss.
  function automatic string kind_word();
    case ($urandom_range(0, 19))
      0:       return "attach";
      1:       return "attachmentx";
      2:       return "pd";
      3:       return "pdfx";
      4:       return "PDF";
      5:       return "";
      6, 7, 8, 9, 10, 11, 12: return "pdf";
      default: return "attachment";
    endcase
  endfunction

  function automatic void build_good_key();
    put_str("dom:v1/");
    put_str(kind_word());
    put_str("/");
    put_carrier($urandom_range(1, 6));
    put_str("/");
    put_tokens($urandom_range(1, 5));
    put_str("/");
    put_tokens($urandom_range(1, 5));
  endfunction

  // One random defect in an otherwise well-formed key.
  function automatic void corrupt_key();
    int pos;
    pos = $urandom_range(0, key_buf.size() - 1);
    case ($urandom_range(0, 5))
      0: key_buf[pos] = 8'($urandom_range(0, 255));
      1: key_buf[pos] = CH_SLASH;
      2: key_buf[pos] = CH_PERCENT;
      3: while (key_buf.size() > pos + 1) void'(key_buf.pop_back());
      4: begin
        put_str("/");
        if ($urandom_range(0, 1) == 0) put_tokens($urandom_range(1, 3));
      end
      default: key_buf.insert(pos, CH_SLASH);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  task automatic report_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) begin
      report_error($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  // Receiver stall: switches between no stall, light, heavy and periodic modes.
  initial begin : receiver_stall
    int mode;
    int left;
    int tick;
    out_stall_i = 1'b0;
    mode = 0;
    left = 0;
    tick = 0;
    forever begin
      @(posedge clk_i);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(32, 200);
      end
      left--;
      tick++;
      case (mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 3) == 0);
        2:       out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= (tick % 7) < 3;
      endcase
    end
  end

  // Each accepted result against the oldest expectation.
  always @(posedge clk_i) begin : check_results
    dksp_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (parse_results_q.size() == 0) begin
        report_error("result with no request outstanding");
      end else begin
        want = parse_results_q.pop_front();
        check_field("byte_valid", 8'(byte_valid_o), 8'(want.byte_valid));
        check_field("decoded_byte", decoded_byte_o, want.decoded_byte);
        check_field("segment", 8'(segment_o), 8'(want.segment));
        check_field("key_done", 8'(key_done_o), 8'(want.key_done));
        check_field("key_ok", 8'(key_ok_o), 8'(want.key_ok));
        check_field("kind_pdf", 8'(kind_pdf_o), 8'(want.kind_pdf));
      end
    end
  end

  // Ends the run when nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni ||
        (in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Both carrier kinds; byte extremes raw and escaped; every name character class.
  task automatic test_valid_keys();
    put_str("dom:v1/pdf/a/b/c");
    send_key();
    put_str("dom:v1/attachment/");
    put_byte(8'h00);
    put_byte(8'hFF);
    put_str("%00%FF%fA%7e/0z_./9a._");
    send_key();
  endtask

  // Malformed keys, one defect each, plus bytes after a failure.
  task automatic test_special_cases();
    put_byte(8'hFF);                        // single byte, fails in the prefix
    send_key();
    put_str("dom:v1/pdf");                  // ends inside the kind
    send_key();
    put_str("dom:v1/pdf/ab%4");             // ends with an escape pending
    send_key();
    put_str("dom:v1/pdf/%4g/a/b");          // non-hex digit, later bytes ignored
    send_key();
    put_str("dom:v1/pdf/%/a/b");            // slash right after '%'
    send_key();
    put_str("dom:v1/pdf/a/b/c/d");          // fifth segment
    send_key();
    put_str("dom:v1/pdf//a/b");             // empty carrier key
    send_key();
    put_str("dom:v1/pdf/a/b/");             // empty name
    send_key();
    put_str("dom:v1/attachmen/a/b/c");      // short kind
    send_key();
    put_str("dom:v1/pdf/a/B/c");            // uppercase in namespace
    send_key();
  endtask

  // Mostly well-formed keys with random content, some corrupted, some noise.
  task automatic test_random_keys();
    int start;
    int pick;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 12)) put_byte(8'($urandom_range(0, 255)));
      end else if (pick < 12) begin
        put_str("dom:v1/");
        repeat ($urandom_range(1, 12)) put_byte(8'($urandom_range(0, 255)));
      end else begin
        build_good_key();
        if (pick >= 65) corrupt_key();
      end
      send_key();
      if ($urandom_range(0, 39) == 0) wait_drained();
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    key_byte_i     = '0;
    last_byte_i    = 1'b0;
    mismatch_count = 0;
    bytes_sent     = 0;
    burst_left     = 0;
    parse_restart();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_valid_keys();
    test_special_cases();
    wait_drained();
    test_random_keys();
    wait_drained();

    if (parse_results_q.size() != 0) report_error("expected results left over");
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
